/* rtl/core/lrb_pkg.sv */
// ----------------------------------------------------------------------------
// lrb_pkg
// Shared types, constants and tables of the landmark range and bearing block.
// ----------------------------------------------------------------------------
package lrb_pkg;

  // Default distance limit, Q16.16 metres.
  localparam int DIST_LIMIT_DEF   = 327680;
  // Default number of CORDIC iterations.
  localparam int CORDIC_STEPS_DEF = 20;
  // Most CORDIC iterations the arctangent table supports.
  localparam int MAX_STEPS        = 32;

  // Stages of the range path after the transform; the bearing path matches it.
  localparam int SQRT_LAT = 35;

  // Input and result widths.
  localparam int ID_W   = 10;
  localparam int POS_W  = 32;
  localparam int COEF_W = 18;
  localparam int BEAR_W = 19;

  // CORDIC datapath widths.
  localparam int CX_W = 52;
  localparam int Z_W  = 36;

  // Pi in Q32 radians.
  localparam logic signed [Z_W-1:0] PI_Q32 = 36'sd13493037705;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ROT_XX  = 3'd0,
    REG_ROT_XY  = 3'd1,
    REG_ROT_XZ  = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_ROT_YX  = 3'd4,
    REG_ROT_YY  = 3'd5,
    REG_ROT_YZ  = 3'd6,
    REG_SHIFT_Y = 3'd7
  } reg_idx_t;

  // Configuration register set.
  typedef struct packed {
    logic signed [COEF_W-1:0] rot_xx;
    logic signed [COEF_W-1:0] rot_xy;
    logic signed [COEF_W-1:0] rot_xz;
    logic signed [POS_W-1:0]  shift_x;
    logic signed [COEF_W-1:0] rot_yx;
    logic signed [COEF_W-1:0] rot_yy;
    logic signed [COEF_W-1:0] rot_yz;
    logic signed [POS_W-1:0]  shift_y;
  } cfg_t;

  // Result item, out_id in the lowest bits.
  typedef struct packed {
    logic signed [BEAR_W-1:0] bearing;
    logic [POS_W-1:0]         range;
    logic [ID_W-1:0]          out_id;
  } res_t;

  // Arctangent of 2^-i in Q32 radians, rounded to nearest.
  function automatic logic [32:0] atan_q32(input logic [4:0] idx);
    logic [32:0] v;
    case (idx)
      5'd0:    v = 33'd3373259426;
      5'd1:    v = 33'd1991351317;
      5'd2:    v = 33'd1052175346;
      5'd3:    v = 33'd534100635;
      5'd4:    v = 33'd268086748;
      5'd5:    v = 33'd134174063;
      5'd6:    v = 33'd67103403;
      5'd7:    v = 33'd33553749;
      5'd8:    v = 33'd16777131;
      5'd9:    v = 33'd8388597;
      5'd10:   v = 33'd4194303;
      5'd11:   v = 33'd2097152;
      5'd12:   v = 33'd1048576;
      5'd13:   v = 33'd524288;
      5'd14:   v = 33'd262144;
      5'd15:   v = 33'd131072;
      5'd16:   v = 33'd65536;
      5'd17:   v = 33'd32768;
      5'd18:   v = 33'd16384;
      5'd19:   v = 33'd8192;
      5'd20:   v = 33'd4096;
      5'd21:   v = 33'd2048;
      5'd22:   v = 33'd1024;
      5'd23:   v = 33'd512;
      5'd24:   v = 33'd256;
      5'd25:   v = 33'd128;
      5'd26:   v = 33'd64;
      5'd27:   v = 33'd32;
      5'd28:   v = 33'd16;
      5'd29:   v = 33'd8;
      5'd30:   v = 33'd4;
      5'd31:   v = 33'd2;
      default: v = 33'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/lrb_xform.sv */
// ----------------------------------------------------------------------------
// lrb_xform
// Distance gate and rigid transform into the robot frame, three stages.
// ----------------------------------------------------------------------------
module lrb_xform #(
  parameter int DIST_LIMIT = lrb_pkg::DIST_LIMIT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [lrb_pkg::ID_W-1:0]        in_id,
  input  logic signed [lrb_pkg::POS_W-1:0] cam_x,
  input  logic signed [lrb_pkg::POS_W-1:0] cam_y,
  input  logic signed [lrb_pkg::POS_W-1:0] cam_z,
  input  lrb_pkg::cfg_t                   cfg,
  output logic                            out_valid,
  output logic [lrb_pkg::ID_W-1:0]        out_id,
  output logic signed [lrb_pkg::POS_W-1:0] x,
  output logic signed [lrb_pkg::POS_W-1:0] y
);

  localparam logic [63:0] LIM2 = 64'(DIST_LIMIT) * 64'(DIST_LIMIT);

  // Saturate a 37-bit sum to signed 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -37'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Stage 1: squares and transform products.
  logic signed [63:0] sqx, sqy, sqz;
  logic signed [49:0] pxx, pxy, pxz, pyx, pyy, pyz;

  assign sqx = cam_x * cam_x;
  assign sqy = cam_y * cam_y;
  assign sqz = cam_z * cam_z;
  assign pxx = cfg.rot_xx * cam_x;
  assign pxy = cfg.rot_xy * cam_y;
  assign pxz = cfg.rot_xz * cam_z;
  assign pyx = cfg.rot_yx * cam_x;
  assign pyy = cfg.rot_yy * cam_y;
  assign pyz = cfg.rot_yz * cam_z;

  logic                     v1_r;
  logic [lrb_pkg::ID_W-1:0] id1_r;
  logic [62:0]              sqx_r, sqy_r, sqz_r;
  logic signed [49:0]       pxx_r, pxy_r, pxz_r, pyx_r, pyy_r, pyz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      id1_r <= in_id;
      sqx_r <= sqx[62:0];
      sqy_r <= sqy[62:0];
      sqz_r <= sqz[62:0];
      pxx_r <= pxx;
      pxy_r <= pxy;
      pxz_r <= pxz;
      pyx_r <= pyx;
      pyy_r <= pyy;
      pyz_r <= pyz;
    end
  end

  // Stage 2: squared norm and row sums.
  logic                     v2_r;
  logic [lrb_pkg::ID_W-1:0] id2_r;
  logic [63:0]              n2_r;
  logic signed [51:0]       accx_r, accy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      id2_r  <= id1_r;
      n2_r   <= 64'(sqx_r) + 64'(sqy_r) + 64'(sqz_r);
      accx_r <= 52'(pxx_r) + 52'(pxy_r) + 52'(pxz_r);
      accy_r <= 52'(pyx_r) + 52'(pyy_r) + 52'(pyz_r);
    end
  end

  // Stage 3: gate on distance, round to Q16.16, add the offset and saturate.
  logic               far;
  logic signed [51:0] rndx, rndy;
  logic signed [36:0] sumx, sumy;

  assign far  = n2_r > LIM2;
  assign rndx = accx_r + 52'sd32768;
  assign rndy = accy_r + 52'sd32768;
  assign sumx = 37'($signed(rndx[51:16])) + 37'(cfg.shift_x);
  assign sumy = 37'($signed(rndy[51:16])) + 37'(cfg.shift_y);

  logic v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r & ~far;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_id <= id2_r;
      x      <= sat32(sumx);
      y      <= sat32(sumy);
    end
  end

  assign out_valid = v3_r;

endmodule

/* rtl/core/lrb_sqrt.sv */
// ----------------------------------------------------------------------------
// lrb_sqrt
// Planar range: squares, sum, one root bit per stage, then rounding.
// ----------------------------------------------------------------------------
module lrb_sqrt (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [lrb_pkg::ID_W-1:0]         in_id,
  input  logic signed [lrb_pkg::POS_W-1:0] x,
  input  logic signed [lrb_pkg::POS_W-1:0] y,
  output logic                             out_valid,
  output logic [lrb_pkg::ID_W-1:0]         out_id,
  output logic [lrb_pkg::POS_W-1:0]        range
);

  localparam int BITS = 32;

  // Stage A: squares.
  logic signed [63:0]       xx, yy;
  logic                     va_r;
  logic [lrb_pkg::ID_W-1:0] ida_r;
  logic [62:0]              xx_r, yy_r;

  assign xx = x * x;
  assign yy = y * y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ida_r <= in_id;
      xx_r  <= xx[62:0];
      yy_r  <= yy[62:0];
    end
  end

  // Root stages; entry 0 is the sum stage.
  logic                     v_r   [0:BITS];
  logic [lrb_pkg::ID_W-1:0] id_r  [0:BITS];
  logic [31:0]              q_r   [0:BITS];
  logic [63:0]              rem_r [0:BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      id_r[0]  <= ida_r;
      q_r[0]   <= 32'd0;
      rem_r[0] <= 64'(xx_r) + 64'(yy_r);
    end
  end

  for (genvar j = 0; j < BITS; j++) begin : g_bit
    localparam int K = BITS - 1 - j;
    logic [65:0] trial;
    logic        ge;

    // Try root bit K against the remainder.
    assign trial = (66'(q_r[j]) << (K + 1)) | (66'(1) << (2 * K));
    assign ge    = {2'b00, rem_r[j]} >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (en) begin
        v_r[j+1] <= v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        id_r[j+1]  <= id_r[j];
        q_r[j+1]   <= ge ? (q_r[j] | (32'(1) << K)) : q_r[j];
        rem_r[j+1] <= ge ? (rem_r[j] - trial[63:0]) : rem_r[j];
      end
    end
  end

  // Round to nearest: step up when the remainder exceeds the root.
  logic        vo_r;
  logic [31:0] range_nxt;

  assign range_nxt = (rem_r[BITS] > 64'(q_r[BITS])) ? q_r[BITS] + 32'd1 : q_r[BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_id <= id_r[BITS];
      range  <= range_nxt;
    end
  end

  assign out_valid = vo_r;

endmodule

/* rtl/core/lrb_cordic.sv */
// ----------------------------------------------------------------------------
// lrb_cordic
// Bearing by vectoring CORDIC, one iteration per stage, delayed to match range.
// ----------------------------------------------------------------------------
module lrb_cordic #(
  parameter int STEPS = lrb_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [lrb_pkg::POS_W-1:0]  x,
  input  logic signed [lrb_pkg::POS_W-1:0]  y,
  output logic signed [lrb_pkg::BEAR_W-1:0] bearing
);

  localparam int CXW = lrb_pkg::CX_W;
  localparam int ZW  = lrb_pkg::Z_W;
  localparam int PAD = lrb_pkg::SQRT_LAT - STEPS - 2;

  // Prep: fold the left half plane and start the angle at plus or minus pi.
  logic signed [32:0]    x33, y33, xn, yn;
  logic                  neg;
  logic signed [ZW-1:0]  z0;

  assign x33 = 33'(x);
  assign y33 = 33'(y);
  assign neg = x[31];
  assign xn  = neg ? -x33 : x33;
  assign yn  = neg ? -y33 : y33;
  assign z0  = neg ? (y[31] ? -lrb_pkg::PI_Q32 : lrb_pkg::PI_Q32) : '0;

  logic signed [CXW-1:0] cx_r  [0:STEPS];
  logic signed [CXW-1:0] cy_r  [0:STEPS];
  logic signed [ZW-1:0]  z_r   [0:STEPS];
  logic                  org_r [0:STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0]  <= CXW'(xn) <<< 16;
      cy_r[0]  <= CXW'(yn) <<< 16;
      z_r[0]   <= z0;
      org_r[0] <= (x == '0) && (y == '0);
    end
  end

  // Rotation stages.
  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    logic signed [CXW-1:0] dx, dy;
    logic signed [ZW-1:0]  ang;
    logic                  dn;

    assign dx  = cy_r[i] >>> i;
    assign dy  = cx_r[i] >>> i;
    assign ang = ZW'(lrb_pkg::atan_q32(5'(i)));
    assign dn  = cy_r[i][CXW-1];

    always_ff @(posedge clk) begin
      if (en) begin
        cx_r[i+1]  <= dn ? cx_r[i] - dx : cx_r[i] + dx;
        cy_r[i+1]  <= dn ? cy_r[i] + dy : cy_r[i] - dy;
        z_r[i+1]   <= dn ? z_r[i] - ang : z_r[i] + ang;
        org_r[i+1] <= org_r[i];
      end
    end
  end

  // Round the angle half up to Q16; the origin reads as zero.
  logic signed [ZW-1:0]               zr;
  logic signed [lrb_pkg::BEAR_W-1:0]  bear_r [0:PAD];

  assign zr = z_r[STEPS] + ZW'(32768);

  always_ff @(posedge clk) begin
    if (en) begin
      bear_r[0] <= org_r[STEPS] ? '0 : zr[34:16];
    end
  end

  // Delay line to line up with the range path.
  for (genvar p = 0; p < PAD; p++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) begin
        bear_r[p+1] <= bear_r[p];
      end
    end
  end

  assign bearing = bear_r[PAD];

endmodule

/* rtl/core/lrb_skid.sv */
// ----------------------------------------------------------------------------
// lrb_skid
// Output register with a skid entry; stalls the pipeline only when both fill.
// ----------------------------------------------------------------------------
module lrb_skid (
  input  logic          clk,
  input  logic          rst_n,
  output logic          en,
  input  logic          in_valid,
  input  lrb_pkg::res_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lrb_pkg::res_t out_data
);

  logic          out_v_r, skid_v_r;
  lrb_pkg::res_t out_d_r, skid_d_r;
  logic          drain;

  // The pipeline moves while the skid entry is empty.
  assign en    = ~skid_v_r;
  assign drain = out_ready | ~out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (drain) begin
      out_v_r  <= skid_v_r | in_valid;
      skid_v_r <= 1'b0;
    end else if (in_valid && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_d_r <= skid_v_r ? skid_d_r : in_data;
    end
    if (!drain && en) begin
      skid_d_r <= in_data;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

/* rtl/core/landmark_range_bearing_top.sv */
// ----------------------------------------------------------------------------
// landmark_range_bearing_top
// Marker position to planar range and bearing in the robot frame.
// ----------------------------------------------------------------------------
// One marker request is taken every clock while the result side keeps up; a
// result passes three transform stages, 35 stages of the bit-per-stage square
// root with the CORDIC alongside, and the output register. Markers beyond the
// distance limit produce no result. The output register has a skid entry
// behind it, so input stalls only once two finished results are waiting.
// Configuration is to be written by the user only while the block is idle;
// the block itself does not enforce this.
module landmark_range_bearing_top #(
  parameter int DIST_LIMIT   = lrb_pkg::DIST_LIMIT_DEF,
  parameter int CORDIC_STEPS = lrb_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // marker_id[9:0], cam_x[41:10], cam_y[73:42], cam_z[105:74], zero fill
  input  logic [111:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // out_id[9:0], range[41:10], bearing[60:42], zero fill
  output logic [63:0]  out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  // Configuration registers.
  lrb_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{rot_xx: 18'sd65536, rot_yy: 18'sd65536, default: '0};
    end else if (cfg_we) begin
      case (lrb_pkg::reg_idx_t'(cfg_index))
        lrb_pkg::REG_ROT_XX:  cfg_r.rot_xx  <= cfg_wdata[17:0];
        lrb_pkg::REG_ROT_XY:  cfg_r.rot_xy  <= cfg_wdata[17:0];
        lrb_pkg::REG_ROT_XZ:  cfg_r.rot_xz  <= cfg_wdata[17:0];
        lrb_pkg::REG_SHIFT_X: cfg_r.shift_x <= cfg_wdata;
        lrb_pkg::REG_ROT_YX:  cfg_r.rot_yx  <= cfg_wdata[17:0];
        lrb_pkg::REG_ROT_YY:  cfg_r.rot_yy  <= cfg_wdata[17:0];
        lrb_pkg::REG_ROT_YZ:  cfg_r.rot_yz  <= cfg_wdata[17:0];
        lrb_pkg::REG_SHIFT_Y: cfg_r.shift_y <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Request fields.
  logic [lrb_pkg::ID_W-1:0]         marker_id;
  logic signed [lrb_pkg::POS_W-1:0] cam_x, cam_y, cam_z;

  assign marker_id = in_tdata[9:0];
  assign cam_x     = in_tdata[41:10];
  assign cam_y     = in_tdata[73:42];
  assign cam_z     = in_tdata[105:74];

  logic en;
  assign in_tready = en;

  // Distance gate and transform.
  logic                             xf_valid;
  logic [lrb_pkg::ID_W-1:0]         xf_id;
  logic signed [lrb_pkg::POS_W-1:0] xf_x, xf_y;

  lrb_xform #(
    .DIST_LIMIT (DIST_LIMIT)
  ) u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_id     (marker_id),
    .cam_x     (cam_x),
    .cam_y     (cam_y),
    .cam_z     (cam_z),
    .cfg       (cfg_r),
    .out_valid (xf_valid),
    .out_id    (xf_id),
    .x         (xf_x),
    .y         (xf_y)
  );

  // Range path, carrying valid and id.
  lrb_pkg::res_t res;
  logic          res_valid;

  lrb_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (xf_valid),
    .in_id     (xf_id),
    .x         (xf_x),
    .y         (xf_y),
    .out_valid (res_valid),
    .out_id    (res.out_id),
    .range     (res.range)
  );

  // Bearing path, same latency as the range path.
  lrb_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .en      (en),
    .x       (xf_x),
    .y       (xf_y),
    .bearing (res.bearing)
  );

  // Output register and skid entry.
  lrb_pkg::res_t out_res;

  lrb_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (res_valid),
    .in_data   (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {3'b000, out_res};

endmodule

/* rtl/core/lrb_chk.sv */
// ----------------------------------------------------------------------------
// lrb_chk
// Port-level checks of the landmark range and bearing block.
// ----------------------------------------------------------------------------
module lrb_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic [63:0]  out_tdata,
  input logic         out_tvalid,
  input logic         out_tready
);

  // No result is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Input only backs up while a result is waiting.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result waiting");

  // Bearing stays within plus or minus pi.
  a_bearing: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[60:42]) >= -19'sd205888) &&
                   ($signed(out_tdata[60:42]) <= 19'sd205888))
    else $error("bearing out of range");

  // Range cannot exceed the diagonal of the saturated square.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[41:10] <= 32'd3037000500)
    else $error("range out of bounds");

endmodule

bind landmark_range_bearing_top lrb_chk u_lrb_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

/* tb/landmark_range_bearing_top_tb.sv */
// ----------------------------------------------------------------------------
// landmark_range_bearing_top_tb
// Self-checking bench for the marker range and bearing block.
// ----------------------------------------------------------------------------
// Marker requests are driven on the input stream. Each accepted request is
// run through a local model of the distance check, the transform, the square
// root and the CORDIC. The model's results are queued, and every result leaving
// the block is compared with the oldest queued one. Several idle and stall
// settings are run, and so are several transform settings with the extremes
// among them.
module landmark_range_bearing_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint LIMIT_SQ    = 64'(lrb_pkg::DIST_LIMIT_DEF) *
                                   64'(lrb_pkg::DIST_LIMIT_DEF);
  localparam int     SETTLE_CYC  = 60;
  localparam int     WATCHDOG    = 6000;
  localparam longint PI_RAD_Q32  = 64'd13493037705;

  // Arctangent of 2^-i in Q32 radians.
  localparam longint ATAN_TBL [0:31] = '{
    64'sd3373259426, 1991351317, 1052175346, 534100635, 268086748, 134174063,
    67103403, 33553749, 16777131, 8388597, 4194303, 2097152, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
    128, 64, 32, 16, 8, 4, 2};

  logic         clk;
  logic         rst_n;
  logic [111:0] in_tdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [63:0]  out_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_wdata;

  lrb_pkg::cfg_t cur_cfg;
  lrb_pkg::res_t pending_res[$];
  int   err_cnt;
  int   snd_idle_pct;
  int   rcv_stall_pct;
  int   hold_cycles;
  int   quiet_cnt;

  landmark_range_bearing_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // One transform row, rounded half up, shifted and saturated.
  function automatic longint map_row(longint a, longint b, longint c, longint t,
                                     longint px, longint py, longint pz);
    longint acc;
    acc = ((a * px + b * py + c * pz + 32768) >>> 16) + t;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc;
  endfunction

  // Square root of a 64-bit value, rounded to nearest.
  function automatic longint unsigned round_sqrt(longint unsigned s);
    longint unsigned r, b, rem;
    r = 0;
    rem = s;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (rem > r) r += 1;
    return r;
  endfunction

  // Vectoring CORDIC angle in Q16 radians.
  function automatic longint cordic_angle(longint x, longint y);
    longint z, cx, cy, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_RAD_Q32 : -PI_RAD_Q32;
      x = -x;
      y = -y;
    end
    cx = x * 65536;
    cy = y * 65536;
    for (int i = 0; i < lrb_pkg::CORDIC_STEPS_DEF; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; z += ATAN_TBL[i];
      end else begin
        cx -= dx; cy += dy; z -= ATAN_TBL[i];
      end
    end
    return (z + 32768) >>> 16;
  endfunction

  // Expected result of one marker; returns 0 when it is beyond the limit.
  function automatic bit range_bearing_of(logic [lrb_pkg::ID_W-1:0] id,
                                          logic signed [lrb_pkg::POS_W-1:0] cx,
                                          logic signed [lrb_pkg::POS_W-1:0] cy,
                                          logic signed [lrb_pkg::POS_W-1:0] cz,
                                          output lrb_pkg::res_t r);
    longint px, py, pz, x, y, ang;
    logic [64:0] n2;
    px = cx; py = cy; pz = cz;
    n2 = 65'(64'(px * px)) + 65'(64'(py * py));
    if (n2[64]) n2 = {1'b0, {64{1'b1}}};
    n2 = n2 + 65'(64'(pz * pz));
    if (n2[64]) n2 = {1'b0, {64{1'b1}}};
    r = '0;
    if (n2[63:0] > LIMIT_SQ) return 1'b0;
    x = map_row(cur_cfg.rot_xx, cur_cfg.rot_xy, cur_cfg.rot_xz, cur_cfg.shift_x,
                px, py, pz);
    y = map_row(cur_cfg.rot_yx, cur_cfg.rot_yy, cur_cfg.rot_yz, cur_cfg.shift_y,
                px, py, pz);
    ang = cordic_angle(x, y);
    r.out_id  = id;
    r.range   = 32'(round_sqrt(64'(x * x) + 64'(y * y)));
    r.bearing = ang[lrb_pkg::BEAR_W-1:0];
    return 1'b1;
  endfunction

  // Send one marker request and queue its expected result once accepted.
  task automatic send_marker(logic [lrb_pkg::ID_W-1:0] id, logic [lrb_pkg::POS_W-1:0] x,
                             logic [lrb_pkg::POS_W-1:0] y, logic [lrb_pkg::POS_W-1:0] z);
    lrb_pkg::res_t r;
    if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tdata  <= {6'b0, z, y, x, id};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (range_bearing_of(id, x, y, z, r)) pending_res = {pending_res, r};
  endtask

  // Wait until every expected result is out and the pipeline has emptied.
  task automatic drain_block();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Write one register; the block must be idle.
  task automatic write_reg(lrb_pkg::reg_idx_t idx, logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      lrb_pkg::REG_ROT_XX:  cur_cfg.rot_xx  = v[lrb_pkg::COEF_W-1:0];
      lrb_pkg::REG_ROT_XY:  cur_cfg.rot_xy  = v[lrb_pkg::COEF_W-1:0];
      lrb_pkg::REG_ROT_XZ:  cur_cfg.rot_xz  = v[lrb_pkg::COEF_W-1:0];
      lrb_pkg::REG_SHIFT_X: cur_cfg.shift_x = v;
      lrb_pkg::REG_ROT_YX:  cur_cfg.rot_yx  = v[lrb_pkg::COEF_W-1:0];
      lrb_pkg::REG_ROT_YY:  cur_cfg.rot_yy  = v[lrb_pkg::COEF_W-1:0];
      lrb_pkg::REG_ROT_YZ:  cur_cfg.rot_yz  = v[lrb_pkg::COEF_W-1:0];
      lrb_pkg::REG_SHIFT_Y: cur_cfg.shift_y = v;
      default: ;
    endcase
  endtask

  // Random coordinate: mostly near the sensor, sometimes anywhere.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0, 1:    return $urandom();
      2:       return 32'($signed($urandom_range(600)) - 300);
      default: return 32'($signed($urandom_range(400000)) - 200000);
    endcase
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++)
      send_marker(10'($urandom()), rand_coord(), rand_coord(), rand_coord());
  endtask

  // Identity transform: special angles, origin and the distance boundary.
  task automatic test_directed();
    send_marker(10'd0,    32'd0, 32'd0, 32'd0);
    send_marker(10'd1023, 32'd65536, 32'd0, 32'd0);
    send_marker(10'd1,    -32'sd65536, 32'd0, 32'd0);
    send_marker(10'd2,    -32'sd65536, -32'sd1, 32'd0);
    send_marker(10'd3,    32'd0, 32'd100000, 32'd0);
    send_marker(10'd4,    32'd0, -32'sd100000, 32'd0);
    send_marker(10'd5,    -32'sd50000, 32'd50000, 32'd0);
    send_marker(10'd6,    32'd327680, 32'd0, 32'd0);
    send_marker(10'd7,    32'd327681, 32'd0, 32'd0);
    send_marker(10'd8,    32'd0, 32'd0, -32'sd327680);
    send_marker(10'd9,    32'd0, -32'sd327681, 32'd0);
    send_marker(10'd10,   32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_marker(10'd11,   32'h80000000, 32'h80000000, 32'h80000000);
    send_marker(10'd12,   32'h80000000, 32'd0, 32'd0);
    send_marker(10'd13,   32'd1, 32'd1, 32'd1);
    send_marker(10'd14,   -32'sd1, 32'd0, 32'd0);
    drain_block();
  endtask

  // Extreme coefficients and shifts so the transform saturates both ways.
  task automatic test_extreme_config();
    write_reg(lrb_pkg::REG_ROT_XX, 32'h0001ffff);
    write_reg(lrb_pkg::REG_ROT_XY, 32'hfffe0000);
    write_reg(lrb_pkg::REG_ROT_XZ, 32'h0001ffff);
    write_reg(lrb_pkg::REG_SHIFT_X, 32'h7fffffff);
    write_reg(lrb_pkg::REG_ROT_YX, 32'hfffe0000);
    write_reg(lrb_pkg::REG_ROT_YY, 32'h0001ffff);
    write_reg(lrb_pkg::REG_ROT_YZ, 32'hfffe0000);
    write_reg(lrb_pkg::REG_SHIFT_Y, 32'h80000000);
    send_marker(10'd20, 32'd327680, 32'd0, 32'd0);
    send_marker(10'd21, -32'sd200000, 32'd100000, 32'd50000);
    send_marker(10'd22, 32'd0, 32'd0, 32'd0);
    send_random(40);
    drain_block();
    write_reg(lrb_pkg::REG_SHIFT_X, 32'h80000000);
    write_reg(lrb_pkg::REG_SHIFT_Y, 32'h7fffffff);
    write_reg(lrb_pkg::REG_ROT_XX, 32'hfffe0000);
    write_reg(lrb_pkg::REG_ROT_YY, 32'hfffe0000);
    send_random(40);
    drain_block();
  endtask

  // Random transform settings under one idle and stall setting.
  task automatic test_random_phase(int snd_pct, int rcv_pct, int n);
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    for (int k = 0; k < 2; k++) begin
      for (int r = 0; r < 8; r++) begin
        if (r == lrb_pkg::REG_SHIFT_X || r == lrb_pkg::REG_SHIFT_Y)
          write_reg(lrb_pkg::reg_idx_t'(r), ($urandom_range(3) == 0) ? $urandom()
                    : 32'($signed($urandom_range(400000)) - 200000));
        else
          write_reg(lrb_pkg::reg_idx_t'(r), $urandom());
      end
      send_random(n / 2);
      drain_block();
    end
  endtask

  // Receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_cycles   = 200;
    send_random(150);
    drain_block();
  endtask

  // Result checking.
  always @(posedge clk) begin
    lrb_pkg::res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(lrb_pkg::res_t)-1:0];
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result id=%0d range=%0d bearing=%0d",
                 $time, got.out_id, got.range, got.bearing);
        err_cnt++;
      end else begin
        want = pending_res.pop_front();
        if (got.out_id !== want.out_id) begin
          $display("%0t: out_id expected %0d actual %0d", $time, want.out_id,
                   got.out_id);
          err_cnt++;
        end
        if (got.range !== want.range) begin
          $display("%0t: range expected %0d actual %0d", $time, want.range,
                   got.range);
          err_cnt++;
        end
        if (got.bearing !== want.bearing) begin
          $display("%0t: bearing expected %0d actual %0d", $time,
                   want.bearing, got.bearing);
          err_cnt++;
        end
      end
    end
  end

  // Receiver: random stalls, and a long hold counted down cycle by cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(rcv_stall_pct > 0 && $urandom_range(99) < rcv_stall_pct);
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= WATCHDOG) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst_n         = 1'b0;
    in_tdata      = '0;
    in_tvalid     = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    err_cnt       = 0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_cycles   = 0;
    quiet_cnt     = 0;
    cur_cfg       = '{rot_xx: 18'sd65536, rot_yy: 18'sd65536, default: '0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_extreme_config();
    test_random_phase(0, 0, 300);
    test_random_phase(58, 0, 300);
    test_random_phase(0, 58, 300);
    test_random_phase(10, 10, 300);
    test_backpressure();

    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
